/* hdl/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// Types, character codes and helpers shared by the script tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

  typedef enum logic [2:0] {
    MODE_SKIP  = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_BLOCK = 3'd3,
    MODE_STAR  = 3'd4,
    MODE_QUOTE = 3'd5,
    MODE_WORD  = 3'd6
  } mode_t;

  // register indexes on the configuration port
  localparam logic CFG_BREAK_LOW  = 1'b0;
  localparam logic CFG_BREAK_HIGH = 1'b1;

  localparam logic [63:0] BREAK_LOW_RESET  = 64'd288234224442408960;
  localparam logic [63:0] BREAK_HIGH_RESET = 64'd2882303761517117440;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_end;
    logic       from_quotes;
    logic       empty_token;
    logic       text_done;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } slot_t;

  // up to two results per accepted byte, in order
  typedef struct packed {
    slot_t s0;
    slot_t s1;
  } push_t;

  function automatic logic is_break(input logic [7:0] b, input logic [63:0] low,
                                    input logic [63:0] high);
    logic r;
    if (b[7])
      r = 1'b0;
    else if (b[6])
      r = high[b[5:0]];
    else
      r = low[b[5:0]];
    return r;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic e, input logic q,
                                  input logic m, input logic d);
    res_t r;
    r.token_byte  = b;
    r.token_end   = e;
    r.from_quotes = q;
    r.empty_token = m;
    r.text_done   = d;
    return r;
  endfunction

  // result caused by a byte arriving between tokens, if any
  function automatic slot_t start_slot(input logic [7:0] b, input logic brk);
    slot_t s;
    s.vld = 1'b0;
    s.res = mk_res(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0);
    if (b == CH_NUL) begin
      s.vld = 1'b1;
      s.res = mk_res(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
    end else if (b > CH_SPACE && b != CH_SLASH && b != CH_QUOTE && brk) begin
      s.vld = 1'b1;
      s.res = mk_res(b, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/stok_lexer.sv */
// ----------------------------------------------------------------------------
// stok_lexer
// Front end: holds the break masks and the lexer state, classifies each
// accepted byte and produces zero, one or two results for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_lexer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_write,
  input  wire logic           cfg_index,
  input  wire logic [63:0]    cfg_data,
  input  wire logic           take,
  input  wire logic [7:0]     text_byte,
  output stok_pkg::push_t     push
);
  import stok_pkg::*;

  logic [63:0] break_low;
  logic [63:0] break_high;
  mode_t       mode, mode_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;

  logic brk_b, brk_slash, word_end;

  assign brk_b     = is_break(text_byte, break_low, break_high);
  assign brk_slash = is_break(CH_SLASH, break_low, break_high);
  assign word_end  = (text_byte <= CH_SPACE) || brk_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_low  <= BREAK_LOW_RESET;
      break_high <= BREAK_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BREAK_LOW:  break_low  <= cfg_data;
        CFG_BREAK_HIGH: break_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SKIP;
      held_byte  <= CH_NUL;
      held_valid <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
    end
  end

  // next state
  always_comb begin
    logic do_start;
    do_start        = 1'b0;
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    unique case (mode)
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_next       = MODE_LINE;
          held_byte_next  = CH_NUL;
          held_valid_next = 1'b0;
        end else if (text_byte == CH_STAR) begin
          mode_next       = MODE_BLOCK;
          held_byte_next  = CH_NUL;
          held_valid_next = 1'b0;
        end else if (brk_slash || word_end) begin
          do_start = 1'b1;
        end else begin
          mode_next       = MODE_WORD;
          held_byte_next  = text_byte;
          held_valid_next = 1'b1;
        end
      end
      MODE_LINE: begin
        if (text_byte == CH_NUL || text_byte == CH_NL) do_start = 1'b1;
      end
      MODE_BLOCK: begin
        if (text_byte == CH_NUL) do_start = 1'b1;
        else if (text_byte == CH_STAR) mode_next = MODE_STAR;
      end
      MODE_STAR: begin
        if (text_byte == CH_NUL) do_start = 1'b1;
        else if (text_byte == CH_SLASH) mode_next = MODE_SKIP;
        else if (text_byte != CH_STAR) mode_next = MODE_BLOCK;
      end
      MODE_QUOTE: begin
        if (text_byte == CH_NUL || text_byte == CH_QUOTE) begin
          mode_next       = MODE_SKIP;
          held_byte_next  = CH_NUL;
          held_valid_next = 1'b0;
        end else begin
          held_byte_next  = text_byte;
          held_valid_next = 1'b1;
        end
      end
      MODE_WORD: begin
        if (word_end) begin
          do_start = 1'b1;
        end else begin
          held_byte_next  = text_byte;
          held_valid_next = 1'b1;
        end
      end
      default: do_start = 1'b1;
    endcase

    if (do_start) begin
      held_byte_next  = CH_NUL;
      held_valid_next = 1'b0;
      if (text_byte <= CH_SPACE) begin
        mode_next = MODE_SKIP;
      end else if (text_byte == CH_SLASH) begin
        mode_next       = MODE_SLASH;
        held_byte_next  = text_byte;
        held_valid_next = 1'b1;
      end else if (text_byte == CH_QUOTE) begin
        mode_next = MODE_QUOTE;
      end else if (brk_b) begin
        mode_next = MODE_SKIP;
      end else begin
        mode_next       = MODE_WORD;
        held_byte_next  = text_byte;
        held_valid_next = 1'b1;
      end
    end
  end

  // results
  always_comb begin
    slot_t st, r0, r1;
    st = start_slot(text_byte, brk_b);
    r0 = '0;
    r1 = '0;
    unique case (mode)
      MODE_SLASH: begin
        if (text_byte != CH_SLASH && text_byte != CH_STAR) begin
          r0.vld = 1'b1;
          if (brk_slash || word_end) begin
            r0.res = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0);
            r1     = st;
          end else begin
            r0.res = mk_res(CH_SLASH, 1'b0, 1'b0, 1'b0, 1'b0);
          end
        end
      end
      MODE_LINE, MODE_BLOCK, MODE_STAR: begin
        // only end of text gives a result inside a comment
        if (text_byte == CH_NUL) r0 = st;
      end
      MODE_QUOTE: begin
        if (text_byte == CH_NUL || text_byte == CH_QUOTE) begin
          r0.vld = 1'b1;
          r0.res = held_valid ? mk_res(held_byte, 1'b1, 1'b1, 1'b0, 1'b0)
                              : mk_res(CH_NUL, 1'b1, 1'b1, 1'b1, 1'b0);
          if (text_byte == CH_NUL) begin
            r1.vld = 1'b1;
            r1.res = mk_res(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
          end
        end else if (held_valid) begin
          r0.vld = 1'b1;
          r0.res = mk_res(held_byte, 1'b0, 1'b1, 1'b0, 1'b0);
        end
      end
      MODE_WORD: begin
        r0.vld = 1'b1;
        r0.res = mk_res(held_byte, word_end, 1'b0, 1'b0, 1'b0);
        if (word_end) r1 = st;
      end
      default: r0 = st;
    endcase
    push.s0     = r0;
    push.s0.vld = r0.vld & take;
    push.s1     = r1;
    push.s1.vld = r1.vld & take;
  end

endmodule

`default_nettype wire

/* hdl/stok_queue.sv */
// ----------------------------------------------------------------------------
// stok_queue
// Back end: a short result queue taking up to two results a cycle and
// presenting one result a cycle on the output channel unless out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stok_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output stok_pkg::res_t      out_res
);
  import stok_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count, count_next;
  logic          pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (count != '0);
  assign out_res   = mem[head];
  assign pop       = out_valid && !out_stall;
  // keep space for a two-result byte
  assign room      = (count <= CW'(DEPTH - 2));

  always_comb begin
    count_next = count + CW'(push.s0.vld) + CW'(push.s1.vld) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) head <= inc(head);
      if (push.s0.vld && push.s1.vld) tail <= inc(inc(tail));
      else if (push.s0.vld) tail <= inc(tail);
    end
  end

  always_ff @(posedge clk) begin
    if (push.s0.vld) mem[tail] <= push.s0.res;
    if (push.s1.vld) mem[inc(tail)] <= push.s1.res;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count beyond depth");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.s1.vld |-> push.s0.vld)
    else $error("second result pushed without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.s0.vld || push.s1.vld) |-> (count <= CW'(DEPTH - 2)) || pop)
    else $error("results pushed into a full queue");

endmodule

`default_nettype wire

/* hdl/script_tokenizer.sv */
// A result is written into the result queue when the byte that causes it is accepted.
// Throughput: one text byte per cycle unless text_stall is high; the result queue
// drains one result per cycle unless token_stall is high. A byte that causes two
// results takes two queue slots; the input stalls while fewer than two slots are free.
// Reset (rst, synchronous): lexer back to whitespace skip, queue empty, break masks
// to their defaults.
// ----------------------------------------------------------------------------
// script_tokenizer
// Streaming tokenizer for script text: one byte in, token bytes out with the
// last byte of each token marked.
// ----------------------------------------------------------------------------
`default_nettype none

module script_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_byte,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [7:0]       token_byte,
  output logic             token_end,
  output logic             from_quotes,
  output logic             empty_token,
  output logic             text_done
);
  import stok_pkg::*;

  push_t push;
  res_t  res;
  logic  room;
  logic  take;

  assign text_stall = !room;
  assign take       = text_valid && room;

  stok_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .text_byte (text_byte),
    .push      (push)
  );

  stok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (token_valid),
    .out_stall (token_stall),
    .out_res   (res)
  );

  assign token_byte  = res.token_byte;
  assign token_end   = res.token_end;
  assign from_quotes = res.from_quotes;
  assign empty_token = res.empty_token;
  assign text_done   = res.text_done;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the script tokenizer. Script text is streamed in a
// byte at a time under random gaps and output stalls. A behavioral lexer
// inside the bench predicts every token result, and a monitor compares each
// result field by field. The run covers several break-mask settings.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int RANDOM_PER_PHASE = 195;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_BREAK_LOW;
  logic [63:0] cfg_data = '0;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [7:0]  token_byte;
  logic        token_end;
  logic        from_quotes;
  logic        empty_token;
  logic        text_done;

  script_tokenizer dut (.*);

  always #10 clk = ~clk;

  // lexer state as the bench sees it
  logic [127:0] break_set = {BREAK_HIGH_RESET, BREAK_LOW_RESET};
  mode_t        lex_mode = MODE_SKIP;
  logic [7:0]   held_ch = '0;
  bit           held_ok = 1'b0;

  logic [7:0] text_queue[$];
  res_t       expected_tokens[$];
  int         bytes_queued = 0;
  int         bytes_offered = 0;
  int         bytes_taken = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  int         send_gap = 0;
  int         hold_left = 0;
  int         quiet_left[2] = '{0, 0};

  function automatic bit char_breaks(input logic [7:0] c);
    return !c[7] && break_set[c[6:0]];
  endfunction

  task automatic expect_result(input logic [7:0] c, input bit last, input bit quoted,
                               input bit empty, input bit done);
    res_t r;
    r.token_byte  = c;
    r.token_end   = last;
    r.from_quotes = quoted;
    r.empty_token = empty;
    r.text_done   = done;
    expected_tokens.push_back(r);
  endtask

  // byte arriving between tokens
  task automatic open_token(input logic [7:0] c);
    held_ok = 1'b0;
    held_ch = CH_NUL;
    if (c == CH_NUL) begin
      lex_mode = MODE_SKIP;
      expect_result(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
    end else if (c <= CH_SPACE) begin
      lex_mode = MODE_SKIP;
    end else if (c == CH_SLASH) begin
      lex_mode = MODE_SLASH;
      held_ch = c;
      held_ok = 1'b1;
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_QUOTE;
    end else if (char_breaks(c)) begin
      lex_mode = MODE_SKIP;
      expect_result(c, 1'b1, 1'b0, 1'b0, 1'b0);
    end else begin
      lex_mode = MODE_WORD;
      held_ch = c;
      held_ok = 1'b1;
    end
  endtask

  // release the held word byte; c ends the word or joins it
  task automatic extend_word(input logic [7:0] c);
    if (c <= CH_SPACE || char_breaks(c)) begin
      expect_result(held_ch, 1'b1, 1'b0, 1'b0, 1'b0);
      open_token(c);
    end else begin
      expect_result(held_ch, 1'b0, 1'b0, 1'b0, 1'b0);
      held_ch = c;
      held_ok = 1'b1;
      lex_mode = MODE_WORD;
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    case (lex_mode)
      MODE_SLASH: begin
        if (c == CH_SLASH || c == CH_STAR) begin
          lex_mode = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          held_ok = 1'b0;
          held_ch = CH_NUL;
        end else if (char_breaks(CH_SLASH)) begin
          expect_result(CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0);
          open_token(c);
        end else begin
          held_ch = CH_SLASH;
          extend_word(c);
        end
      end
      MODE_LINE: begin
        if (c == CH_NUL || c == CH_NL) open_token(c);
      end
      MODE_BLOCK: begin
        if (c == CH_NUL) open_token(c);
        else if (c == CH_STAR) lex_mode = MODE_STAR;
      end
      MODE_STAR: begin
        if (c == CH_NUL) open_token(c);
        else if (c == CH_SLASH) lex_mode = MODE_SKIP;
        else if (c != CH_STAR) lex_mode = MODE_BLOCK;
      end
      MODE_QUOTE: begin
        if (c == CH_NUL || c == CH_QUOTE) begin
          if (held_ok) expect_result(held_ch, 1'b1, 1'b1, 1'b0, 1'b0);
          else expect_result(CH_NUL, 1'b1, 1'b1, 1'b1, 1'b0);
          held_ok = 1'b0;
          held_ch = CH_NUL;
          lex_mode = MODE_SKIP;
          if (c == CH_NUL) expect_result(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
          if (held_ok) expect_result(held_ch, 1'b0, 1'b1, 1'b0, 1'b0);
          held_ch = c;
          held_ok = 1'b1;
        end
      end
      MODE_WORD: extend_word(c);
      default: open_token(c);
    endcase
  endtask

  // side 0 is the text sender, side 1 the token receiver
  function automatic int pick_gap(input int side);
    int roll;
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    repeat (16) begin
      c = 8'($urandom_range(33, 255));
      if (!char_breaks(c)) return c;
    end
    return 8'h80 | 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] break_char();
    logic [7:0] c;
    repeat (32) begin
      c = 8'($urandom_range(33, 127));
      if (c != CH_SLASH && c != CH_QUOTE && char_breaks(c)) return c;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_byte(input logic [7:0] c);
    text_queue.push_back(c);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // mostly well-formed script text with random content; some pieces left open
  task automatic compose_text();
    int pick;
    int roll;
    int len;
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        repeat (len) queue_byte(word_char());
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(1, 32)));
      end else if (pick < 60) begin
        queue_byte(break_char());
      end else if (pick < 74) begin
        queue_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(1, 255));
          queue_byte((c == CH_QUOTE) ? CH_SPACE : c);
        end
        if ($urandom_range(0, 9) != 0) queue_byte(CH_QUOTE);
      end else if (pick < 82) begin
        queue_byte(CH_SLASH);
        queue_byte(CH_SLASH);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(1, 255));
          queue_byte((c == CH_NL) ? CH_STAR : c);
        end
        if ($urandom_range(0, 9) != 0) queue_byte(CH_NL);
      end else if (pick < 90) begin
        queue_byte(CH_SLASH);
        queue_byte(CH_STAR);
        repeat ($urandom_range(0, 8)) begin
          roll = $urandom_range(0, 9);
          c = (roll < 3) ? CH_STAR : (roll < 5) ? CH_SLASH : 8'($urandom_range(1, 255));
          queue_byte(c);
        end
        if ($urandom_range(0, 9) != 0) begin
          queue_byte(CH_STAR);
          queue_byte(CH_SLASH);
        end
      end else if (pick < 94) begin
        queue_byte(CH_SLASH);
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
      end
    end
    queue_byte(CH_NUL);
  endtask

  task automatic fill_random(input int count);
    int goal;
    goal = bytes_queued + count;
    while (bytes_queued < goal) compose_text();
  endtask

  task automatic wait_idle();
    while (text_queue.size() > 0 || bytes_taken != bytes_offered ||
           expected_tokens.size() > 0)
      @(posedge clk);
    // let the lexer settle before touching the masks
    repeat (4) @(posedge clk);
  endtask

  task automatic write_break_mask(input logic idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_BREAK_LOW) break_set[63:0] = value;
    else break_set[127:64] = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic [63:0] low, input logic [63:0] high);
    write_break_mask(CFG_BREAK_LOW, low);
    write_break_mask(CFG_BREAK_HIGH, high);
    fill_random(RANDOM_PER_PHASE);
    wait_idle();
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // text sender: hold the request until it is taken, then advance
  always @(negedge clk) begin
    if (!rst && (!text_valid || bytes_taken == bytes_offered)) begin
      if (send_gap > 0) begin
        text_valid <= 1'b0;
        send_gap--;
      end else if (text_queue.size() > 0) begin
        text_byte  <= text_queue.pop_front();
        text_valid <= 1'b1;
        bytes_offered++;
        send_gap = pick_gap(0);
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      token_stall <= 1'b1;
      hold_left--;
    end else begin
      token_stall <= 1'b0;
      hold_left = pick_gap(1);
    end
  end

  always @(posedge clk) begin
    if (!rst && text_valid && !text_stall) begin
      bytes_taken++;
      lex_byte(text_byte);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("token result with none expected: token_byte %0d text_done %0d",
               token_byte, text_done);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_byte", want.token_byte, token_byte);
        check_field("token_end", 8'(want.token_end), 8'(token_end));
        check_field("from_quotes", 8'(want.from_quotes), 8'(from_quotes));
        check_field("empty_token", 8'(want.empty_token), 8'(empty_token));
        check_field("text_done", 8'(want.text_done), 8'(text_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default masks: comment marks inside a word, slash-star-slash,
    // empty quotes, slash starting a word, high bytes ended by end of text
    queue_text("a// /*/ */\"\"/(");
    queue_byte(8'hFF);
    queue_byte(CH_NUL);
    wait_idle();

    // everything below 128 breaks: comments and quotes still win at a token
    // start, lone slash is a break, end of text inside a quote and a comment
    write_break_mask(CFG_BREAK_LOW, '1);
    write_break_mask(CFG_BREAK_HIGH, '1);
    queue_text("//x\n/a\"q");
    queue_byte(CH_NUL);
    queue_text("/*");
    queue_byte(CH_NUL);
    fill_random(RANDOM_PER_PHASE);
    wait_idle();

    run_phase('0, '0);
    run_phase(BREAK_LOW_RESET, BREAK_HIGH_RESET);
    run_phase({$urandom, $urandom} | (64'd1 << CH_SLASH) | (64'd1 << CH_QUOTE),
              {$urandom, $urandom});
    run_phase({$urandom, $urandom}, {$urandom, $urandom});
    run_phase({$urandom, $urandom} & ~(64'd1 << CH_SLASH), '1);

    repeat (8) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
